[hw/rtl/kmr_pkg.sv]
// Package for the key macro recorder: opcodes, register indexes and shared structs.
package kmr_pkg;

  typedef enum logic [3:0] {
    OP_START_REC = 4'd0,
    OP_STOP_REC  = 4'd1,
    OP_PLAY      = 4'd2,
    OP_CANCEL    = 4'd3,
    OP_CAPTURE   = 4'd4,
    OP_INJECT    = 4'd5,
    OP_HAS       = 4'd6,
    OP_SAVE      = 4'd7,
    OP_CLEAR     = 4'd8
  } kmr_op_t;

  localparam int EXCL_COUNT = 6;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_E = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_F = 3'd5;

  // Marks "no slot" in the record and play slot registers.
  localparam logic [1:0] NO_SLOT = 2'd3;

  typedef struct packed {
    logic wr;
    logic rd;
  } kmr_mem_ctl_t;

  typedef struct packed {
    logic answer;
    logic inject_hit;
    logic is_recording;
    logic is_playing;
    logic unsaved;
  } kmr_res_t;

endpackage

[hw/rtl/kmr_ctrl.sv]
// Recorder control: excluded codes, slot lengths, record/play state and store access.
module kmr_ctrl import kmr_pkg::*; #(
  parameter int SLOT_COUNT = 3,
  parameter int MAX_KEYS   = 1024,
  parameter int LEN_W      = 11,
  parameter int ADDR_W     = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 step,
  input  logic [3:0]           opcode,
  input  logic [1:0]           slot_sel,
  input  logic [7:0]           key_value,
  input  logic                 key_down,
  output kmr_mem_ctl_t         mem_ctl,
  output logic [ADDR_W-1:0]    mem_addr,
  output kmr_res_t             res
);

  logic [7:0]       excl [EXCL_COUNT];
  logic [LEN_W-1:0] slot_length [SLOT_COUNT];
  logic [LEN_W-1:0] slot_length_next [SLOT_COUNT];
  logic             recording_flag, recording_flag_next;
  logic [1:0]       record_slot, record_slot_next;
  logic             playing_flag, playing_flag_next;
  logic [1:0]       play_slot, play_slot_next;
  logic [LEN_W-1:0] play_position, play_position_next;
  logic             dirty_flag, dirty_flag_next;

  logic [LEN_W-1:0] sel_len, rec_len, play_len, rec_len_inc;
  logic             slot_ok, excluded;
  logic             answer, inject_hit;
  logic [1:0]       acc_slot;
  logic [LEN_W-1:0] acc_off;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KEYS);

  always_comb begin
    sel_len  = '0;
    rec_len  = '0;
    play_len = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (32'(slot_sel) == i)    sel_len  = slot_length[i];
      if (32'(record_slot) == i) rec_len  = slot_length[i];
      if (32'(play_slot) == i)   play_len = slot_length[i];
    end
    excluded = 1'b0;
    for (int i = 0; i < EXCL_COUNT; i++) begin
      if (excl[i] == key_value) excluded = 1'b1;
    end
  end

  assign slot_ok     = 32'(slot_sel) < SLOT_COUNT;
  assign rec_len_inc = rec_len + LEN_W'(1);

  always_comb begin
    slot_length_next    = slot_length;
    recording_flag_next = recording_flag;
    record_slot_next    = record_slot;
    playing_flag_next   = playing_flag;
    play_slot_next      = play_slot;
    play_position_next  = play_position;
    dirty_flag_next     = dirty_flag;
    answer              = 1'b0;
    inject_hit          = 1'b0;
    mem_ctl             = '0;
    acc_slot            = record_slot;
    acc_off             = rec_len;
    case (kmr_op_t'(opcode))
      OP_START_REC: begin
        if (slot_ok) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (32'(slot_sel) == i) slot_length_next[i] = '0;
          end
          recording_flag_next = 1'b1;
          record_slot_next    = slot_sel;
          playing_flag_next   = 1'b0;
          play_slot_next      = NO_SLOT;
          play_position_next  = '0;
        end
      end
      OP_STOP_REC: begin
        recording_flag_next = 1'b0;
        record_slot_next    = NO_SLOT;
        dirty_flag_next     = 1'b1;
      end
      OP_PLAY: begin
        if (slot_ok && sel_len != '0) begin
          recording_flag_next = 1'b0;
          record_slot_next    = NO_SLOT;
          playing_flag_next   = 1'b1;
          play_slot_next      = slot_sel;
          play_position_next  = '0;
          answer              = 1'b1;
        end
      end
      OP_CANCEL: begin
        playing_flag_next  = 1'b0;
        play_slot_next     = NO_SLOT;
        play_position_next = '0;
      end
      OP_CAPTURE: begin
        if (recording_flag && key_down && !excluded) begin
          dirty_flag_next = 1'b1;
          if (rec_len >= MAX_LEN) begin
            recording_flag_next = 1'b0;
            record_slot_next    = NO_SLOT;
          end else begin
            mem_ctl.wr = 1'b1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (32'(record_slot) == i) slot_length_next[i] = rec_len_inc;
            end
            // slot just filled: recording ends by itself
            if (rec_len_inc >= MAX_LEN) begin
              recording_flag_next = 1'b0;
              record_slot_next    = NO_SLOT;
            end
          end
        end
      end
      OP_INJECT: begin
        acc_slot = play_slot;
        acc_off  = play_position;
        if (playing_flag) begin
          if (play_position >= play_len || play_position >= MAX_LEN) begin
            playing_flag_next  = 1'b0;
            play_slot_next     = NO_SLOT;
            play_position_next = '0;
          end else begin
            mem_ctl.rd         = 1'b1;
            play_position_next = play_position + LEN_W'(1);
            answer             = 1'b1;
            inject_hit         = 1'b1;
          end
        end
      end
      OP_HAS: begin
        answer = slot_ok && sel_len != '0;
      end
      OP_SAVE: begin
        answer          = dirty_flag;
        dirty_flag_next = 1'b0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) slot_length_next[i] = '0;
        recording_flag_next = 1'b0;
        record_slot_next    = NO_SLOT;
        playing_flag_next   = 1'b0;
        play_slot_next      = NO_SLOT;
        play_position_next  = '0;
        dirty_flag_next     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign mem_addr = ADDR_W'(32'(acc_slot) * MAX_KEYS + 32'(acc_off));

  always_comb begin
    res.answer       = answer;
    res.inject_hit   = inject_hit;
    res.is_recording = recording_flag_next;
    res.is_playing   = playing_flag_next;
    res.unsaved      = dirty_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EXCL_COUNT; i++) excl[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXCL_A: excl[0] <= cfg_data;
        CFG_EXCL_B: excl[1] <= cfg_data;
        CFG_EXCL_C: excl[2] <= cfg_data;
        CFG_EXCL_D: excl[3] <= cfg_data;
        CFG_EXCL_E: excl[4] <= cfg_data;
        CFG_EXCL_F: excl[5] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_length[i] <= '0;
      recording_flag <= 1'b0;
      record_slot    <= NO_SLOT;
      playing_flag   <= 1'b0;
      play_slot      <= NO_SLOT;
      play_position  <= '0;
      dirty_flag     <= 1'b0;
    end else if (step) begin
      slot_length    <= slot_length_next;
      recording_flag <= recording_flag_next;
      record_slot    <= record_slot_next;
      playing_flag   <= playing_flag_next;
      play_slot      <= play_slot_next;
      play_position  <= play_position_next;
      dirty_flag     <= dirty_flag_next;
    end
  end

endmodule

[hw/rtl/key_macro_record_playback.sv]
// Top level of the keystroke macro recorder: input register, key store, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  in       | in_valid / in_ready  | opcode, slot_sel, key_value, key_down
//  out      | out_valid / out_ready| answer, injected_key, is_recording, is_playing,
//           |                      | unsaved
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (excluded codes a..f)
//
// One item per cycle sustained while out_ready stays high. The command sits in the
// input register while the control logic updates state and issues one access
// to the single-port key store; the result register captures flags and the
// registered store read data together.
// Reset is synchronous. Slot lengths and flags clear at once; the key store
// has no clearing pass since it is only read below a slot's length.
// A stalled result holds the result register and the read data; the input
// register then holds its item, and in_ready drops until the output drains.
module key_macro_record_playback import kmr_pkg::*; #(
  parameter int SLOT_COUNT = 3,
  parameter int MAX_KEYS   = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           opcode,
  input  logic [1:0]           slot_sel,
  input  logic [7:0]           key_value,
  input  logic                 key_down,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 answer,
  output logic [7:0]           injected_key,
  output logic                 is_recording,
  output logic                 is_playing,
  output logic                 unsaved
);

  localparam int LEN_W  = $clog2(MAX_KEYS + 1);
  localparam int DEPTH  = SLOT_COUNT * MAX_KEYS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // input register
  logic       s1_valid;
  logic [3:0] s1_opcode;
  logic [1:0] s1_slot;
  logic [7:0] s1_key;
  logic       s1_down;

  logic         advance;
  kmr_mem_ctl_t mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  kmr_res_t     res;
  kmr_res_t     out_res;

  logic [7:0] key_store [DEPTH];
  logic [7:0] rd_data;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_opcode <= opcode;
      s1_slot   <= slot_sel;
      s1_key    <= key_value;
      s1_down   <= key_down;
    end
  end

  kmr_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .MAX_KEYS   (MAX_KEYS),
    .LEN_W      (LEN_W),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .opcode    (s1_opcode),
    .slot_sel  (s1_slot),
    .key_value (s1_key),
    .key_down  (s1_down),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .res       (res)
  );

  // key store: at most one write or one read per item
  always_ff @(posedge clk) begin
    if (advance && mem_ctl.wr) begin
      key_store[mem_addr] <= s1_key;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && mem_ctl.rd) begin
      rd_data <= key_store[mem_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign answer       = out_res.answer;
  assign injected_key = out_res.inject_hit ? rd_data : 8'd0;
  assign is_recording = out_res.is_recording;
  assign is_playing   = out_res.is_playing;
  assign unsaved      = out_res.unsaved;

endmodule

[hw/rtl/kmr_checker.sv]
// Port-level checks for the key macro recorder, bound to the top level.
module kmr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       answer,
  input logic [7:0] injected_key,
  input logic       is_recording,
  input logic       is_playing,
  input logic       unsaved
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a nonzero key only comes with a delivered inject
  a_key_answer: assert property (@(posedge clk) disable iff (rst)
    out_valid && injected_key != 8'd0 |-> answer)
    else $error("injected key without answer");

  // recording and playback never run together
  a_rec_play: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_recording && is_playing))
    else $error("recording and playing at once");

  // a fresh result follows an item taken into the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without accepted item");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(answer) && $stable(injected_key)
      && $stable(is_recording) && $stable(is_playing) && $stable(unsaved))
    else $error("stalled result changed");

endmodule

bind key_macro_record_playback kmr_checker u_kmr_checker (.*);
